[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, skipped while reset is high.
`define TRFPC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Same check with a message of its own.
`define TRFPC_ASSERT_MSG(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

[rtl/core/trfpc_pkg.sv]
// Types and codes of the two-register fixed-point calculator.
package trfpc_pkg;

   localparam logic [3:0] OP_PUSH  = 4'd0;
   localparam logic [3:0] OP_ADD   = 4'd1;
   localparam logic [3:0] OP_SUB   = 4'd2;
   localparam logic [3:0] OP_MUL   = 4'd3;
   localparam logic [3:0] OP_POWER = 4'd4;
   localparam logic [3:0] OP_DIV   = 4'd5;
   localparam logic [3:0] OP_SWAP  = 4'd6;
   localparam logic [3:0] OP_CLEAR = 4'd7;
   localparam logic [3:0] OP_MAG   = 4'd8;
   localparam logic [3:0] OP_ROOT  = 4'd9;
   localparam logic [3:0] OP_READ  = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIVZERO  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_NEGROOT  = 2'd3;

   localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] FX_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] operand_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] earlier_value;
      logic signed [31:0] later_value;
      logic [1:0]         status;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } ser_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ser_stat_type;

endpackage

[rtl/core/trfpc_serial.sv]
// Shared shift-subtract unit: restoring divide and digit-by-digit square root.
module trfpc_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  trfpc_pkg::ser_ctl_type  ctl,
   input  logic [63:0]           opnd,
   input  logic [31:0]           divisor,
   output trfpc_pkg::ser_stat_type stat,
   output logic [63:0]           quot,
   output logic [31:0]           root
);
   import trfpc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] shf_ff, shf_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] div_ff, div_in;
   logic [35:0] sub_a, sub_b;
   logic [36:0] diff;
   logic        take;

   // Pick the operands of the one subtractor
   always_comb begin
      if (mode_ff) begin
         sub_a = {rem_ff, shf_ff[63:62]};
         sub_b = {2'b00, root_ff, 2'b01};
      end else begin
         sub_a = {3'b000, rem_ff[31:0], shf_ff[63]};
         sub_b = {4'b0000, div_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      take = !diff[36];
   end

   // Load on start, then advance one digit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      shf_in  = shf_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.sqrt_mode;
         cnt_in  = ctl.sqrt_mode ? 6'd31 : 6'd63;
         shf_in  = opnd;
         rem_in  = '0;
         root_in = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (mode_ff) begin
            rem_in  = take ? diff[33:0] : sub_a[33:0];
            root_in = {root_ff[30:0], take};
            shf_in  = {shf_ff[61:0], 2'b00};
         end else begin
            rem_in = take ? {2'b00, diff[31:0]} : {2'b00, sub_a[31:0]};
            shf_in = {shf_ff[62:0], take};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      shf_ff  <= shf_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = shf_ff;
   assign root      = root_ff;

endmodule

[rtl/core/two_register_fixed_point_calculator.sv]
// Two-register signed fixed-point calculator, top level.
// Each command word gives one response word with both registers and a status.
// Push, add, sub, swap, clear and read go straight to the done state; mul and
// power (n capped at MAX_POWER) use the one 32x32 multiplier; divide, root of
// both registers and magnitude (after squaring both registers on the
// multiplier) use the shared shift-subtract unit (one quotient bit or one root
// digit a cycle). A new command is taken once the previous one has been
// handed to the response register, even if that word still waits.
module two_register_fixed_point_calculator #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_POWER = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  trfpc_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output trfpc_pkg::rsp_word_type rsp_word
);
   import trfpc_pkg::*;

   localparam int CW = $clog2(MAX_POWER + 1);
   localparam logic [32:0] ONE_EXT = 33'd1 << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_MUL_APPLY, S_DIV, S_MAG_E, S_MAG_L, S_MAG_SUM,
      S_MAG_WAIT, S_ROOT_E, S_ROOT_EW, S_ROOT_L, S_ROOT_LW, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        e_ff, e_in, l_ff, l_in, base_ff, base_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [63:0] prod_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in, neg_ff, neg_in, dz_ff, dz_in;
   logic               dsign_ff, dsign_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [31:0]        mul_a, mul_b;
   ser_ctl_type        ser_ctl;
   ser_stat_type       ser_stat;
   logic [63:0]        ser_opnd, ser_quot;
   logic [31:0]        ser_div, ser_root;

   logic signed [63:0] prod_sh;
   logic               mul_fits;
   logic [31:0]        mul_sat;
   logic [32:0]        sum_ext, dif_ext, n_full;
   logic [31:0]        abs_l, abs_e;
   logic               e_gt_one;
   logic [CW-1:0]      pwr_n;
   logic [1:0]         st_now;

   trfpc_serial u_serial (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ser_ctl),
      .opnd    (ser_opnd),
      .divisor (ser_div),
      .stat    (ser_stat),
      .quot    (ser_quot),
      .root    (ser_root)
   );

   // Saturating helpers over the register values
   always_comb begin
      prod_sh  = prod_ff >>> FRAC_BITS;
      mul_fits = (&prod_sh[63:31]) || !(|prod_sh[63:31]);
      mul_sat  = mul_fits ? prod_sh[31:0] : (prod_sh[63] ? FX_MIN : FX_MAX);
      sum_ext  = {l_ff[31], l_ff} + {e_ff[31], e_ff};
      dif_ext  = {l_ff[31], l_ff} - {e_ff[31], e_ff};
      abs_l    = l_ff[31] ? (~l_ff + 32'd1) : l_ff;
      abs_e    = e_ff[31] ? (~e_ff + 32'd1) : e_ff;
      e_gt_one = !e_ff[31] && ({1'b0, e_ff} > ONE_EXT);
      n_full   = (({1'b0, e_ff} + ONE_EXT - 33'd1) >> FRAC_BITS) - 33'd1;
      pwr_n    = (n_full > 33'(MAX_POWER)) ? CW'(MAX_POWER) : n_full[CW-1:0];
      if (neg_ff)      st_now = ST_NEGROOT;
      else if (ovf_ff) st_now = ST_OVERFLOW;
      else if (dz_ff)  st_now = ST_DIVZERO;
      else             st_now = ST_OK;
   end

   // Sequence the command
   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      l_in         = l_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      dsign_in     = dsign_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mul_a        = l_ff;
      mul_b        = base_ff;
      ser_ctl      = '0;
      ser_opnd     = '0;
      ser_div      = abs_e;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ovf_in   = 1'b0;
               neg_in   = 1'b0;
               dz_in    = 1'b0;
               state_in = S_DONE;
               unique case (req_word.operation)
                  OP_PUSH: begin
                     e_in = l_ff;
                     l_in = req_word.operand_value;
                  end
                  OP_ADD: begin
                     ovf_in = sum_ext[32] != sum_ext[31];
                     l_in   = (sum_ext[32] != sum_ext[31])
                              ? (sum_ext[32] ? FX_MIN : FX_MAX) : sum_ext[31:0];
                  end
                  OP_SUB: begin
                     ovf_in = dif_ext[32] != dif_ext[31];
                     l_in   = (dif_ext[32] != dif_ext[31])
                              ? (dif_ext[32] ? FX_MIN : FX_MAX) : dif_ext[31:0];
                  end
                  OP_MUL: begin
                     base_in  = e_ff;
                     cnt_in   = CW'(1);
                     state_in = S_MUL;
                  end
                  OP_POWER: begin
                     base_in = l_ff;
                     cnt_in  = pwr_n;
                     if (e_gt_one) state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (e_ff == 32'd0) begin
                        dz_in = 1'b1;
                     end else begin
                        ser_ctl.start = 1'b1;
                        ser_opnd      = {32'd0, abs_l} << FRAC_BITS;
                        dsign_in      = l_ff[31] ^ e_ff[31];
                        state_in      = S_DIV;
                     end
                  end
                  OP_SWAP: begin
                     e_in = l_ff;
                     l_in = e_ff;
                  end
                  OP_CLEAR: begin
                     e_in = '0;
                     l_in = '0;
                  end
                  OP_MAG:  state_in = S_MAG_E;
                  OP_ROOT: state_in = S_ROOT_E;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL: state_in = S_MUL_APPLY;
         S_MUL_APPLY: begin
            l_in   = mul_sat;
            ovf_in = ovf_ff || !mul_fits;
            cnt_in = cnt_ff - CW'(1);
            state_in = (cnt_ff == CW'(1)) ? S_DONE : S_MUL;
         end
         S_DIV: begin
            if (ser_stat.done) begin
               state_in = S_DONE;
               if (dsign_ff) begin
                  if (ser_quot > 64'h8000_0000) begin
                     l_in = FX_MIN;
                     ovf_in = 1'b1;
                  end else begin
                     l_in = ~ser_quot[31:0] + 32'd1;
                  end
               end else if (ser_quot > 64'h7FFF_FFFF) begin
                  l_in = FX_MAX;
                  ovf_in = 1'b1;
               end else begin
                  l_in = ser_quot[31:0];
               end
            end
         end
         S_MAG_E: begin
            mul_a    = e_ff;
            mul_b    = e_ff;
            state_in = S_MAG_L;
         end
         S_MAG_L: begin
            mul_a    = l_ff;
            mul_b    = l_ff;
            acc_in   = prod_ff;
            state_in = S_MAG_SUM;
         end
         S_MAG_SUM: begin
            ser_ctl.start     = 1'b1;
            ser_ctl.sqrt_mode = 1'b1;
            ser_opnd          = acc_ff + prod_ff;
            state_in          = S_MAG_WAIT;
         end
         S_MAG_WAIT: begin
            if (ser_stat.done) begin
               state_in = S_DONE;
               if (ser_root[31]) begin
                  l_in = FX_MAX;
                  ovf_in = 1'b1;
               end else begin
                  l_in = ser_root;
               end
            end
         end
         S_ROOT_E: begin
            if (e_ff[31]) begin
               e_in     = '0;
               neg_in   = 1'b1;
               state_in = S_ROOT_L;
            end else begin
               ser_ctl.start     = 1'b1;
               ser_ctl.sqrt_mode = 1'b1;
               ser_opnd          = {32'd0, e_ff} << FRAC_BITS;
               state_in          = S_ROOT_EW;
            end
         end
         S_ROOT_EW: begin
            if (ser_stat.done) begin
               e_in     = ser_root;
               state_in = S_ROOT_L;
            end
         end
         S_ROOT_L: begin
            if (l_ff[31]) begin
               l_in     = '0;
               neg_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               ser_ctl.start     = 1'b1;
               ser_ctl.sqrt_mode = 1'b1;
               ser_opnd          = {32'd0, l_ff} << FRAC_BITS;
               state_in          = S_ROOT_LW;
            end
         end
         S_ROOT_LW: begin
            if (ser_stat.done) begin
               l_in     = ser_root;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hand over the word once the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.earlier_value = e_ff;
               rsp_word_in.later_value   = l_ff;
               rsp_word_in.status        = st_now;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         e_ff         <= '0;
         l_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         e_ff         <= e_in;
         l_ff         <= l_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      prod_ff     <= $signed(mul_a) * $signed(mul_b);
      cnt_ff      <= cnt_in;
      ovf_ff      <= ovf_in;
      neg_ff      <= neg_in;
      dz_ff       <= dz_in;
      dsign_ff    <= dsign_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/trfpc_checker.sv]
// Port-level checks of the calculator and their binding to the top level.
`include "assert_macros.svh"

module trfpc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input trfpc_pkg::req_word_type req_word,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input trfpc_pkg::rsp_word_type rsp_word
);
   import trfpc_pkg::*;

   // A taken command keeps the input closed while it runs
   `TRFPC_ASSERT(busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)

   // A negative root zeroes at least one register
   `TRFPC_ASSERT_MSG(negroot_zero, clock, reset, (rsp_valid && rsp_word.status == ST_NEGROOT) |-> (rsp_word.earlier_value == 0 || rsp_word.later_value == 0), "negative root kept both registers")

   // Hold a stalled response word
   `TRFPC_ASSERT(rsp_hold_valid, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)
   `TRFPC_ASSERT(rsp_hold_word, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_word))

endmodule

bind two_register_fixed_point_calculator trfpc_checker u_trfpc_checker (.*);
